>>> hdl/assert_macros.svh
// Assertion helpers shared by spq_outreg and sorted_array_priority_queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while in reset.
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants for the sorted-array priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] item_value;
    logic        [7:0]  item_priority;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] removed_value;
    logic        [7:0]  removed_priority;
    logic        [3:0]  occupancy;
  } rsp_t;

  // Broadcast to every cell for one beat
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [15:0] value;
    logic        [7:0]  prio;
  } cmd_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic               valid;
    logic signed [15:0] value;
    logic        [7:0]  prio;
    logic               less;
  } link_t;

endpackage

`default_nettype wire

>>> hdl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: keeps, shifts right on insert, shifts left
// on delete.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire spq_pkg::cmd_t  cmd,
  input  wire spq_pkg::link_t left,
  input  wire spq_pkg::link_t right,
  output spq_pkg::link_t      here
);

  logic               valid;
  logic signed [15:0] value;
  logic        [7:0]  prio;
  logic               valid_next;
  logic signed [15:0] value_next;
  logic        [7:0]  prio_next;

  assign here.valid = valid;
  assign here.value = value;
  assign here.prio  = prio;
  // sorted, so these flags form a prefix of the chain
  assign here.less  = valid && (prio < cmd.prio);

  always_comb begin
    valid_next = valid;
    value_next = value;
    prio_next  = prio;
    priority if (cmd.ins) begin
      if (here.less) begin
        // stays put
      end else if (left.less) begin
        valid_next = 1'b1;
        value_next = cmd.value;
        prio_next  = cmd.prio;
      end else begin
        valid_next = left.valid;
        value_next = left.value;
        prio_next  = left.prio;
      end
    end else if (cmd.del) begin
      valid_next = right.valid;
      value_next = right.value;
      prio_next  = right.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

`default_nettype wire

>>> hdl/spq_outreg.sv
// ---------------------------------------------------------------------------
// spq_outreg
// Result register with a skid slot, so a beat is taken while one waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spq_outreg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire spq_pkg::rsp_t result,
  output logic               busy,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output spq_pkg::rsp_t      rsp
);

  logic          skid_valid;
  spq_pkg::rsp_t skid;
  logic          take;

  assign take = rsp_valid && !rsp_stall;
  assign busy = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (rsp_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        rsp <= skid;
      end
    end else if (load) begin
      if (rsp_valid && !take) begin
        skid <= result;
      end else begin
        rsp <= result;
      end
    end
  end

  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst || !skid_valid || rsp_valid, "skid full with output empty")
  `ASSERT_CLK(a_no_load_when_busy, clk, rst, skid_valid |-> !load, "beat loaded while skid full")
  `ASSERT_CLK(a_skid_drains, clk, rst, (skid_valid && take) |=> (rsp_valid && !skid_valid), "skid failed to drain")

endmodule

`default_nettype wire

>>> hdl/sorted_array_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_array_priority_queue
// Bounded priority queue kept as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
//  channel | valid     | stall     | payload | dir
//  --------+-----------+-----------+---------+-----
//  request | req_valid | req_stall | req     | in
//  result  | rsp_valid | rsp_stall | rsp     | out
//
//  One request per cycle while req_stall is low; its result is registered.
//  Each cell compares its own priority with the new one, so the chain
//  length does not lengthen the path beyond one compare and a neighbour mux.
//  req_stall rises only while a result waits in the skid slot.
//  rst empties the queue and drops any pending result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_array_priority_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire spq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output spq_pkg::rsp_t      rsp
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::CNT_W;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            accept;
  logic            full;
  logic            empty;
  logic            busy;
  spq_pkg::cmd_t   cmd;
  spq_pkg::rsp_t   result;
  spq_pkg::link_t  head_edge;
  spq_pkg::link_t  tail_edge;
  spq_pkg::link_t  links [CAP];
  logic [CAP-1:0]  valids;
  logic [CW+3:0]   occ_wide;

  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(CAP));
  assign empty     = (count == '0);

  assign cmd.ins   = accept && (req.mode == spq_pkg::MODE_INSERT) && !full;
  assign cmd.del   = accept && (req.mode == spq_pkg::MODE_DELETE) && !empty;
  assign cmd.value = req.item_value;
  assign cmd.prio  = req.item_priority;

  // the new entry lands in front of the first cell not marked less
  assign head_edge = '{valid: 1'b1, value: '0, prio: '0, less: 1'b1};
  assign tail_edge = '{valid: 1'b0, value: '0, prio: '0, less: 1'b0};

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  ((i == 0) ? head_edge : links[(i == 0) ? 0 : i - 1]),
      .right ((i == CAP - 1) ? tail_edge : links[(i == CAP - 1) ? i : i + 1]),
      .here  (links[i])
    );
    assign valids[i] = links[i].valid;
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.del) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign occ_wide = (CW + 4)'(count_next);

  always_comb begin
    result.status           = spq_pkg::STAT_OK;
    result.removed_value    = '0;
    result.removed_priority = '0;
    result.occupancy        = occ_wide[3:0];
    if (req.mode == spq_pkg::MODE_INSERT) begin
      if (full) begin
        result.status = spq_pkg::STAT_OVERFLOW;
      end
    end else if (empty) begin
      result.status = spq_pkg::STAT_UNDERFLOW;
    end else begin
      result.removed_value    = links[0].value;
      result.removed_priority = links[0].prio;
    end
  end

  spq_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .result    (result),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `ASSERT_CLK(a_count_bound, clk, rst, count <= CW'(CAP), "entry count above capacity")
  `ASSERT_CLK(a_count_matches_cells, clk, rst, $countones(valids) == 32'(count), "count disagrees with cells")
  `ASSERT_CLK(a_valid_prefix, clk, rst, $onehot0(valids + 1'b1) || (valids + 1'b1) == '0, "holes in cell chain")
  `ASSERT_CLK(a_delete_shrinks, clk, rst, cmd.del |=> count == $past(count) - 1'b1, "delete left count unchanged")

endmodule

`default_nettype wire
